/* sv/stks_pkg.sv */
// shared constants and types for the sorted table key search
package stks_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = 10;
  localparam int CNT_W       = IDX_W + 1;
  localparam int KEY_W       = 31;
  localparam int PAY_W       = 32;
  localparam int OP_W        = 2;
  localparam int ENT_W       = KEY_W + PAY_W;

  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_SEQ  = 2'd1;
  localparam logic [OP_W-1:0] OP_BIN  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_DONE
  } state_t;

  // one access to the table memory
  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] addr;
    logic [ENT_W-1:0] wdata;
  } mem_req_t;

endpackage

/* sv/stks_in_if.sv */
// request channel carrying loads and searches
interface stks_in_if;
  import stks_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [IDX_W-1:0] entry_index;
  logic [KEY_W-1:0] entry_key;
  logic [PAY_W-1:0] entry_payload;

  modport source (output valid, opcode, entry_index, entry_key, entry_payload,
                  input ready);
  modport sink (input valid, opcode, entry_index, entry_key, entry_payload,
                output ready);
endinterface

/* sv/stks_out_if.sv */
// result channel carrying search answers
interface stks_out_if;
  import stks_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic [IDX_W-1:0] match_position;
  logic [PAY_W-1:0] match_payload;
  logic [CNT_W-1:0] compare_count;

  modport source (output valid, found, match_position, match_payload, compare_count,
                  input ready);
  modport sink (input valid, found, match_position, match_payload, compare_count,
                output ready);
endinterface

/* sv/sorted_table_key_search.sv */
// sorted table key search top level: config register, table memory, sequencer
//
//  channel   dir  handshake         content
//  in_req    in   valid/ready       opcode, entry_index, entry_key, entry_payload
//  out_res   out  valid/ready       found, match_position, match_payload, compare_count
//  cfg       in   cfg_wr_en only    entries_in_use
//
// a load is written to the table when it is accepted; a sequential scan reads
// one table entry per cycle, and a binary search reads then compares per probe,
// both through the single read port of the table memory; an empty table
// answers without reading the table
// reset clears the sequencer and the entry count, the table itself is not cleared
// a finished result waits in the output register; the next request is taken
// while it waits, and a search only stalls at its end if the result is still held
module sorted_table_key_search (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [stks_pkg::CNT_W-1:0] cfg_wr_data,
  stks_in_if.sink                    in_req,
  stks_out_if.source                 out_res
);
  import stks_pkg::*;

  logic [CNT_W-1:0] entries_r;
  logic [CNT_W-1:0] live_n;
  mem_req_t         mem_req;
  logic [ENT_W-1:0] mem_rdata;

  // entry count register; the user writes it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= '0;
    end else if (cfg_wr_en) begin
      entries_r <= cfg_wr_data;
    end
  end

  // counts above the table size saturate
  assign live_n = (entries_r > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : entries_r;

  // key and payload share one entry word, key in the upper bits
  stks_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.addr),
    .wr_data (mem_req.wdata),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.addr),
    .rd_data (mem_rdata)
  );

  stks_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .live_n    (live_n),
    .in_req    (in_req),
    .out_res   (out_res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  // table writes only come from an accepted load request
  a_wr_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> (in_req.valid && in_req.ready && in_req.opcode == OP_LOAD))
    else $error("table write without a load request");

  // never more compares than live entries
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> (out_res.compare_count <= live_n))
    else $error("compare count exceeds live entries");

  // a hit needs at least one compare
  a_hit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.found) |-> (out_res.compare_count != '0))
    else $error("hit reported with no compare");

  // a miss reports zero position and payload
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.found) |->
      (out_res.match_position == '0 && out_res.match_payload == '0))
    else $error("miss carries nonzero position or payload");

endmodule

/* sv/stks_ram.sv */
// generic single-clock ram with registered read
module stks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/stks_ctrl.sv */
// search sequencer: accepts requests, walks the table memory, holds the result
module stks_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [stks_pkg::CNT_W-1:0] live_n,
  stks_in_if.sink                 in_req,
  stks_out_if.source              out_res,
  output stks_pkg::mem_req_t      mem_req,
  input  logic [stks_pkg::ENT_W-1:0] mem_rdata
);
  import stks_pkg::*;

  state_t           state_r, state_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic             bin_r, bin_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;     // exclusive upper bound
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             hit_r, hit_nxt;
  logic [PAY_W-1:0] pay_r, pay_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r;
  logic [IDX_W-1:0] out_pos_r;
  logic [PAY_W-1:0] out_pay_r;
  logic [CNT_W-1:0] out_cnt_r;

  logic             accept;
  logic             is_search;
  logic             out_free;
  logic [CNT_W:0]   mid_sum;
  logic [IDX_W-1:0] mid;
  logic [KEY_W-1:0] probe_key;
  logic [PAY_W-1:0] probe_pay;
  logic             probe_hit;
  logic             probe_less;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] mid_up;
  logic             seq_last;
  logic             bin_empty;

  assign accept     = in_req.valid && in_req.ready;
  assign is_search  = (in_req.opcode == OP_SEQ) || (in_req.opcode == OP_BIN);
  assign out_free   = !out_valid_r || out_res.ready;
  assign mid_sum    = {1'b0, lo_r} + {1'b0, hi_r} - (CNT_W + 1)'(1);
  assign mid        = mid_sum[IDX_W:1];
  assign probe_key  = mem_rdata[ENT_W-1:PAY_W];
  assign probe_pay  = mem_rdata[PAY_W-1:0];
  assign probe_hit  = (probe_key == key_r);
  assign probe_less = (probe_key < key_r);
  assign cnt_inc    = cnt_r + CNT_W'(1);
  assign mid_up     = {1'b0, pos_r} + CNT_W'(1);
  assign seq_last   = (cnt_inc == n_r);
  // range left after this probe is empty
  assign bin_empty  = probe_less ? (mid_up >= hi_r) : (lo_r >= {1'b0, pos_r});

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && is_search) begin
          state_nxt = (live_n == '0) ? ST_DONE : ST_PROBE;
        end
      end
      ST_PROBE: state_nxt = ST_CMP;
      ST_CMP: begin
        if (probe_hit) begin
          state_nxt = ST_DONE;
        end else if (bin_r) begin
          state_nxt = bin_empty ? ST_DONE : ST_PROBE;
        end else if (seq_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake and memory access
  always_comb begin
    in_req.ready  = 1'b0;
    mem_req       = '0;
    mem_req.wdata = {in_req.entry_key, in_req.entry_payload};
    case (state_r)
      ST_IDLE: begin
        // ready is always high here, so valid alone marks an accepted load
        in_req.ready  = 1'b1;
        mem_req.addr  = in_req.entry_index;
        mem_req.wr_en = in_req.valid && (in_req.opcode == OP_LOAD) &&
                        (32'(in_req.entry_index) < TABLE_DEPTH);
      end
      ST_PROBE: begin
        mem_req.rd_en = 1'b1;
        mem_req.addr  = bin_r ? mid : pos_r;
      end
      ST_CMP: begin
        // sequential scan streams the next entry while this one is compared
        mem_req.rd_en = !bin_r;
        mem_req.addr  = mid_up[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    key_nxt       = key_r;
    bin_nxt       = bin_r;
    n_nxt         = n_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    hit_nxt       = hit_r;
    pay_nxt       = pay_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    case (state_r)
      ST_IDLE: begin
        if (accept && is_search) begin
          key_nxt = in_req.entry_key;
          bin_nxt = (in_req.opcode == OP_BIN);
          n_nxt   = live_n;
          lo_nxt  = '0;
          hi_nxt  = live_n;
          pos_nxt = '0;
          cnt_nxt = '0;
          hit_nxt = 1'b0;
          pay_nxt = '0;
        end
      end
      ST_PROBE: begin
        if (bin_r) begin
          pos_nxt = mid;
        end
      end
      ST_CMP: begin
        cnt_nxt = cnt_inc;
        if (probe_hit) begin
          hit_nxt = 1'b1;
          pay_nxt = probe_pay;
        end else if (bin_r) begin
          if (probe_less) begin
            lo_nxt = mid_up;
          end else begin
            hi_nxt = {1'b0, pos_r};
          end
        end else if (!seq_last) begin
          pos_nxt = mid_up[IDX_W-1:0];
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    bin_r <= bin_nxt;
    n_r   <= n_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    pos_r <= pos_nxt;
    cnt_r <= cnt_nxt;
    hit_r <= hit_nxt;
    pay_r <= pay_nxt;
    if (state_r == ST_DONE && out_free) begin
      out_found_r <= hit_r;
      out_pos_r   <= hit_r ? pos_r : '0;
      out_pay_r   <= hit_r ? pay_r : '0;
      out_cnt_r   <= cnt_r;
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.found          = out_found_r;
  assign out_res.match_position = out_pos_r;
  assign out_res.match_payload  = out_pay_r;
  assign out_res.compare_count  = out_cnt_r;

endmodule
